### rtl/core/tpvd_pkg.sv
// Shared types and constants for the three-phase voltage deviation detector.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tpvd_pkg;

  localparam int NUM_PHASES  = 3;
  localparam int VOLT_W      = 16;
  localparam int THRESH_W    = 15;
  localparam int COUNT_W     = 6;
  localparam int LEVEL_W     = 2;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 15;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_THRESHOLD = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_LIMIT    = 4'd1;

  // Register reset values.
  localparam logic [THRESH_W-1:0] STEP_THRESHOLD_RST = 15'd801;
  localparam logic [COUNT_W-1:0]  COUNT_LIMIT_RST    = 6'd21;

  // Transfer mode in which the check is disabled (interrupted transfer).
  localparam logic [1:0] MODE_INTERRUPTED = 2'd2;

  // Bit positions inside control_flags.
  localparam int FLG_BYP_CHECK   = 0;
  localparam int FLG_INV_CHECK   = 1;
  localparam int FLG_BYP_FAST10  = 2;
  localparam int FLG_INV_FAST    = 3;
  localparam int FLG_BYP_FAST    = 4;
  localparam int FLG_BYP_SWITCH  = 5;
  localparam int FLG_INV_SWITCH  = 6;

  typedef struct packed {
    logic [6:0]               control_flags;
    logic [1:0]               switch_mode;
    logic signed [VOLT_W-1:0] out_volt_a;
    logic signed [VOLT_W-1:0] out_volt_b;
    logic signed [VOLT_W-1:0] out_volt_c;
    logic signed [VOLT_W-1:0] byp_volt_a;
    logic signed [VOLT_W-1:0] byp_volt_b;
    logic signed [VOLT_W-1:0] byp_volt_c;
    logic signed [VOLT_W-1:0] inv_volt_a;
    logic signed [VOLT_W-1:0] inv_volt_b;
    logic signed [VOLT_W-1:0] inv_volt_c;
  } in_t;

  typedef struct packed {
    logic               deviation_fault;
    logic [COUNT_W-1:0] deviation_count;
  } out_t;

  // What the phase lanes hand to the merging stage for one sample.
  typedef struct packed {
    logic                                src_ok;
    logic [NUM_PHASES-1:0][LEVEL_W-1:0] lane_level;
  } lvl_t;

endpackage

`default_nettype wire

### rtl/core/tpvd_lane.sv
// One phase lane: absolute difference of output and source voltage, graded
// against one, two and three step thresholds. Depends on tpvd_pkg.
`default_nettype none

module tpvd_lane (
  input  wire logic signed [tpvd_pkg::VOLT_W-1:0]   out_volt,
  input  wire logic signed [tpvd_pkg::VOLT_W-1:0]   src_volt,
  input  wire logic        [tpvd_pkg::THRESH_W-1:0] step_threshold,
  output logic             [tpvd_pkg::LEVEL_W-1:0]  level
);
  import tpvd_pkg::*;

  logic signed [VOLT_W:0] diff;
  logic        [VOLT_W:0] mag;
  logic        [VOLT_W:0] t1;
  logic        [VOLT_W:0] t2;
  logic        [VOLT_W:0] t3;

  // Full-width difference, so there is no 16-bit wrap.
  assign diff = {out_volt[VOLT_W-1], out_volt} - {src_volt[VOLT_W-1], src_volt};
  assign mag  = diff[VOLT_W] ? (VOLT_W+1)'(-diff) : (VOLT_W+1)'(diff);

  assign t1 = {2'b00, step_threshold};
  assign t2 = {1'b0, step_threshold, 1'b0};
  assign t3 = t2 + t1;

  always_comb begin
    if (mag > t3) begin
      level = 2'd3;
    end else if (mag > t2) begin
      level = 2'd2;
    end else if (mag > t1) begin
      level = 2'd1;
    end else begin
      level = 2'd0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tpvd_merge.sv
// Merging stage: takes the largest lane level and updates the deviation
// counter and fault flag, which also serve as the output register. Depends on tpvd_pkg.
`default_nettype none

module tpvd_merge (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s1_valid,
  input  wire tpvd_pkg::lvl_t                 s1_data,
  output logic                                s1_ready,
  input  wire logic [tpvd_pkg::COUNT_W-1:0]   count_limit,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output tpvd_pkg::out_t                      out_data
);
  import tpvd_pkg::*;

  logic               take;
  logic [LEVEL_W-1:0] lvl_ab;
  logic [LEVEL_W-1:0] lvl_max;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] cnt_next;
  logic               fault;
  logic               fault_next;

  assign s1_ready = !out_valid || out_ready;
  assign take     = s1_valid && s1_ready;

  assign lvl_ab  = (s1_data.lane_level[1] > s1_data.lane_level[0]) ?
                   s1_data.lane_level[1] : s1_data.lane_level[0];
  assign lvl_max = (s1_data.lane_level[2] > lvl_ab) ? s1_data.lane_level[2] : lvl_ab;
  assign sum     = {1'b0, cnt} + {{(COUNT_W+1-LEVEL_W){1'b0}}, lvl_max};

  always_comb begin
    cnt_next   = cnt;
    fault_next = fault;
    if (!s1_data.src_ok) begin
      cnt_next   = '0;
      fault_next = 1'b0;
    end else if (lvl_max != '0) begin
      if (sum > {1'b0, count_limit}) begin
        cnt_next   = count_limit;
        fault_next = 1'b1;
      end else begin
        cnt_next = sum[COUNT_W-1:0];
      end
    end else if (cnt == '0) begin
      // Underflow: counter stays at zero and the fault clears.
      fault_next = 1'b0;
    end else begin
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      fault     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        cnt   <= cnt_next;
        fault <= fault_next;
      end
      if (s1_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  assign out_data.deviation_fault = fault;
  assign out_data.deviation_count = cnt;

  a_no_src_clears: assert property (@(posedge clk) disable iff (rst)
    take && !s1_data.src_ok |=> (cnt == '0) && !fault)
    else $error("counter or flag not cleared without a conducting source");

  a_underflow_clears: assert property (@(posedge clk) disable iff (rst)
    take && s1_data.src_ok && (lvl_max == '0) && (cnt == '0) |=> !fault && (cnt == '0))
    else $error("underflow did not clear the fault");

  a_over_limit_sets: assert property (@(posedge clk) disable iff (rst)
    take && s1_data.src_ok && (lvl_max != '0) && (sum > {1'b0, count_limit})
      |=> fault && (cnt == $past(count_limit)))
    else $error("counter past limit did not clamp and set the fault");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(cnt) && $stable(fault))
    else $error("counter state moved without a transaction");

endmodule

`default_nettype wire

### rtl/core/three_phase_voltage_deviation_detector_top.sv
// Top level of the three-phase output voltage deviation detector.
// Path: a sample is captured in the stage one register and then in the merging stage's
// output register, which raises out_valid; a low out_ready can hold it in either register.
// Throughput: one sample per clock while out_ready is high; three phase lanes grade in parallel
// and the merging stage updates the counter. Only a low out_ready stalls; two samples fit.
// Reset (rst, synchronous, active high): counter and fault clear, step_threshold
// returns to 801 and count_limit to 21, and both pipeline stages empty.
`default_nettype none

module three_phase_voltage_deviation_detector_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire tpvd_pkg::in_t                      in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output tpvd_pkg::out_t                          out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tpvd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [tpvd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tpvd_pkg::*;

  // Configuration registers. Writes are always taken.
  logic [THRESH_W-1:0] step_threshold;
  logic [COUNT_W-1:0]  count_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_threshold <= STEP_THRESHOLD_RST;
      count_limit    <= COUNT_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP_THRESHOLD: step_threshold <= cfg_data[THRESH_W-1:0];
        REG_COUNT_LIMIT:    count_limit    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Enable and source selection. The check runs when either check bit is set,
  // when no fast fault is pending unless the 10 s fast bypass check is active,
  // and when the transfer mode is not interrupted. The bypass wins over the
  // inverter when both switches conduct.
  logic chk;
  logic fast_ok;
  logic enabled;
  logic use_byp;
  logic src_ok;

  assign chk     = in_data.control_flags[FLG_BYP_CHECK] || in_data.control_flags[FLG_INV_CHECK];
  assign fast_ok = in_data.control_flags[FLG_BYP_FAST10] ||
                   (!in_data.control_flags[FLG_INV_FAST] && !in_data.control_flags[FLG_BYP_FAST]);
  assign enabled = chk && fast_ok && (in_data.switch_mode != MODE_INTERRUPTED);
  assign use_byp = in_data.control_flags[FLG_BYP_SWITCH];
  assign src_ok  = enabled && (use_byp || in_data.control_flags[FLG_INV_SWITCH]);

  logic signed [NUM_PHASES-1:0][VOLT_W-1:0] out_v;
  logic signed [NUM_PHASES-1:0][VOLT_W-1:0] src_v;
  logic [NUM_PHASES-1:0][LEVEL_W-1:0]       lane_level;

  assign out_v[0] = in_data.out_volt_a;
  assign out_v[1] = in_data.out_volt_b;
  assign out_v[2] = in_data.out_volt_c;
  assign src_v[0] = use_byp ? in_data.byp_volt_a : in_data.inv_volt_a;
  assign src_v[1] = use_byp ? in_data.byp_volt_b : in_data.inv_volt_b;
  assign src_v[2] = use_byp ? in_data.byp_volt_c : in_data.inv_volt_c;

  // One lane per phase, all working on the same sample.
  for (genvar p = 0; p < NUM_PHASES; p++) begin : g_lane
    tpvd_lane u_lane (
      .out_volt       (out_v[p]),
      .src_volt       (src_v[p]),
      .step_threshold (step_threshold),
      .level          (lane_level[p])
    );
  end

  // Stage one register: lane levels and the source flag of one sample.
  logic s1_valid;
  lvl_t s1_data;
  logic s1_ready;

  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data.src_ok     <= src_ok;
      s1_data.lane_level <= lane_level;
    end
  end

  // The merging stage holds the counter state and the output register.
  tpvd_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .s1_valid    (s1_valid),
    .s1_data     (s1_data),
    .s1_ready    (s1_ready),
    .count_limit (count_limit),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire
